@@ sv/mbrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrp_pkg
// Shared types and constants of the MBR partition table parser: sector layout,
// result status codes, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrp_pkg;

  // sector layout
  localparam int SECTOR_BYTES = 512;
  localparam int POS_W        = $clog2(SECTOR_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int TABLE_BASE   = 'h1BE;
  localparam int TABLE_STRIDE = 16;

  // byte offsets within one partition entry
  localparam logic [3:0] OFS_TYPE   = 4'd4;
  localparam logic [3:0] OFS_START  = 4'd8;
  localparam logic [3:0] OFS_LENGTH = 4'd12;

  // boot signature
  localparam logic [POS_W-1:0] SIG_LOW_POS  = POS_W'(510);
  localparam logic [POS_W-1:0] SIG_HIGH_POS = POS_W'(511);
  localparam logic [7:0]       SIG_LOW      = 8'h55;
  localparam logic [7:0]       SIG_HIGH     = 8'hAA;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int SECT_W  = 32;
  localparam int OFFS_W  = SECT_W + SECTOR_SHIFT;
  localparam int DISK_W  = 48;
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 4;

  // configuration register indexes (paddr bit 3 selects)
  localparam logic REG_SCAN_ENABLE = 1'b0;
  localparam logic REG_DISK_BYTES  = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_PART    = 2'd0,
    ST_NOT_MBR = 2'd1,
    ST_NO_PART = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    take_byte;
    logic    load;
    status_t code;
    logic    last;
  } mbrp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;
    logic sig_ok;
    logic any_valid;
    logic cur_valid;
    logic rest_none;
    logic out_free;
  } mbrp_sts_t;

endpackage

`default_nettype wire

@@ sv/mbrp_stream_if.sv @@
// ----------------------------------------------------------------------------
// mbrp stream interfaces
// Valid/ready channels for sector bytes in and partition results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbrp_in_if
  import mbrp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              first_byte;

  modport source (output valid, byte_value, first_byte, input ready);
  modport sink   (input valid, byte_value, first_byte, output ready);
endinterface

interface mbrp_out_if
  import mbrp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot;
  logic [BYTE_W-1:0] part_type;
  logic [OFFS_W-1:0] start_byte;
  logic [OFFS_W-1:0] length_bytes;
  logic              fits_disk;
  logic              last;

  modport source (output valid, status, slot, part_type, start_byte, length_bytes,
                  fits_disk, last, input ready);
  modport sink   (input valid, status, slot, part_type, start_byte, length_bytes,
                  fits_disk, last, output ready);
endinterface

`default_nettype wire

@@ sv/mbrp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbrp_ctrl
// Controller: takes bytes, then if scan_enable walks the partition entries
// after the signature byte, one result load per cycle while output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrp_ctrl
  import mbrp_pkg::*;
#(
  parameter int IDX_W       = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             scan_enable,
  input  wire mbrp_sts_t        sts,
  output mbrp_cmd_t             cmd,
  output logic [IDX_W-1:0]      idx
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    in_ready      = (state_r == S_RUN);
    cmd.take_byte = in_valid && (state_r == S_RUN);
    cmd.load      = 1'b0;
    cmd.code      = ST_PART;
    cmd.last      = 1'b0;
    case (state_r)
      S_RUN: begin
        if (cmd.take_byte && sts.at_end && scan_enable) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (!sts.sig_ok) begin
          if (sts.out_free) begin
            cmd.load  = 1'b1;
            cmd.code  = ST_NOT_MBR;
            cmd.last  = 1'b1;
            state_nxt = S_RUN;
          end
        end else if (!sts.any_valid) begin
          if (sts.out_free) begin
            cmd.load  = 1'b1;
            cmd.code  = ST_NO_PART;
            cmd.last  = 1'b1;
            state_nxt = S_RUN;
          end
        end else if (sts.cur_valid) begin
          if (sts.out_free) begin
            cmd.load = 1'b1;
            cmd.code = ST_PART;
            cmd.last = sts.rest_none;
            if (sts.rest_none) begin
              state_nxt = S_RUN;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else begin
          // empty entry: skip without output
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

`default_nettype wire

@@ sv/mbrp_dp.sv @@
// ----------------------------------------------------------------------------
// mbrp_dp
// Datapath: byte position counter, partition entry capture, signature check,
// entry valid mask and the result register with byte offset and size check.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrp_dp
  import mbrp_pkg::*;
#(
  parameter int ENTRY_COUNT = 4,
  parameter int IDX_W       = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mbrp_cmd_t         cmd,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [BYTE_W-1:0] byte_value,
  input  wire logic              first_byte,
  input  wire logic [DISK_W-1:0] disk_bytes,
  output mbrp_sts_t              sts,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [BYTE_W-1:0]      out_part_type,
  output logic [OFFS_W-1:0]      out_start_byte,
  output logic [OFFS_W-1:0]      out_length_bytes,
  output logic                   out_fits_disk,
  output logic                   out_last
);

  localparam logic [POS_W-1:0] TBL_LO = POS_W'(TABLE_BASE);
  localparam logic [POS_W-1:0] TBL_HI = POS_W'(TABLE_BASE + TABLE_STRIDE * ENTRY_COUNT);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos;
  logic              sig_low_r;
  logic              sig_ok_r;
  logic [ENTRY_COUNT-1:0] mask_r, mask_now;
  logic [BYTE_W-1:0] type_r   [ENTRY_COUNT];
  logic [SECT_W-1:0] start_r  [ENTRY_COUNT];
  logic [SECT_W-1:0] length_r [ENTRY_COUNT];

  logic [POS_W-1:0]  rel;
  logic [IDX_W-1:0]  cap_idx;
  logic [3:0]        cap_off;
  logic              in_table;
  logic              end_take;

  logic [OFFS_W-1:0] sb, lb;
  logic [OFFS_W:0]   span;
  logic              fits;
  logic              rest_none;

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [SLOT_W-1:0] slot_r;
  logic [BYTE_W-1:0] ptype_r;
  logic [OFFS_W-1:0] sb_r, lb_r;
  logic              fits_r, last_r;

  // byte position, restart on first byte
  assign pos      = first_byte ? '0 : pos_r;
  assign pos_nxt  = pos + 1'b1;
  assign rel      = pos - TBL_LO;
  assign cap_idx  = rel[4 +: IDX_W];
  assign cap_off  = rel[3:0];
  assign in_table = (pos >= TBL_LO) && (pos < TBL_HI);
  assign end_take = cmd.take_byte && (pos == SIG_HIGH_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      sig_low_r <= 1'b0;
    end else if (cmd.take_byte) begin
      pos_r <= pos_nxt;
      if (pos == SIG_LOW_POS) begin
        sig_low_r <= (byte_value == SIG_LOW);
      end
    end
  end

  // partition entry capture, little-endian words
  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_table) begin
      case (cap_off) inside
        OFS_TYPE: begin
          type_r[cap_idx] <= byte_value;
        end
        [OFS_START : OFS_START + 4'd3]: begin
          start_r[cap_idx][8 * cap_off[1:0] +: 8] <= byte_value;
        end
        [OFS_LENGTH : OFS_LENGTH + 4'd3]: begin
          length_r[cap_idx][8 * cap_off[1:0] +: 8] <= byte_value;
        end
        default: begin
        end
      endcase
    end
  end

  // entry valid mask, taken with the last byte
  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      mask_now[i] = (type_r[i] != '0) && (start_r[i] != '0) && (length_r[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (end_take) begin
      mask_r   <= mask_now;
      sig_ok_r <= sig_low_r && (byte_value == SIG_HIGH);
    end
  end

  // any later valid entry left after the cursor
  always_comb begin
    rest_none = 1'b1;
    for (int j = 0; j < ENTRY_COUNT; j++) begin
      if ((j > int'(idx)) && mask_r[j]) begin
        rest_none = 1'b0;
      end
    end
  end

  assign sts.at_end    = (pos == SIG_HIGH_POS);
  assign sts.sig_ok    = sig_ok_r;
  assign sts.any_valid = |mask_r;
  assign sts.cur_valid = mask_r[idx];
  assign sts.rest_none = rest_none;
  assign sts.out_free  = !out_valid_r || out_ready;

  // byte offsets and disk size check for the entry at the cursor
  assign sb   = {start_r[idx], {SECTOR_SHIFT{1'b0}}};
  assign lb   = {length_r[idx], {SECTOR_SHIFT{1'b0}}};
  assign span = {1'b0, sb} + {1'b0, lb};
  assign fits = {{(DISK_W - OFFS_W - 1){1'b0}}, span} <= disk_bytes;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= cmd.code;
      last_r   <= cmd.last;
      if (cmd.code == ST_PART) begin
        slot_r  <= SLOT_W'(idx) + 1'b1;
        ptype_r <= type_r[idx];
        sb_r    <= sb;
        lb_r    <= lb;
        fits_r  <= fits;
      end else begin
        slot_r  <= '0;
        ptype_r <= '0;
        sb_r    <= '0;
        lb_r    <= '0;
        fits_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_slot         = slot_r;
  assign out_part_type    = ptype_r;
  assign out_start_byte   = sb_r;
  assign out_length_bytes = lb_r;
  assign out_fits_disk    = fits_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

@@ sv/mbr_partition_table_parser.sv @@
// ----------------------------------------------------------------------------
// mbr_partition_table_parser
// Parses the partition table of a disk's first sector from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one sector byte per item; first_byte marks byte 0 and
//   restarts the position count, otherwise the count wraps after byte 511.
//   Bytes are taken at one item per cycle while the block is running.
//   After byte 511 (when scan_enable is set) the block stops taking bytes and
//   walks the ENTRY_COUNT partition entries up to the last valid one, one per
//   cycle while the receiver does not stall: either one not-MBR item, one
//   no-partition item, or one record per valid entry, the final one flagged
//   by last. Once byte 511 is taken the controller enters the scan state and
//   loads each result into the result register; an empty entry is skipped
//   without a result, so empty leading entries delay the first one.
//   out_chan is fed from a result register, so the last result may wait for
//   the receiver while bytes of the next sector are taken; a stalled receiver
//   holds the walk on the next record.
//   The APB port holds scan_enable (address 0) and disk_bytes (address 8).
//   Reset clears the position count and the signature flag, sets scan_enable
//   and clears disk_bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mbr_partition_table_parser
  import mbrp_pkg::*;
#(
  parameter int ENTRY_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mbrp_in_if.sink                in_chan,
  mbrp_out_if.source             out_chan,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic      [APB_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  logic              scan_en_r;
  logic [DISK_W-1:0] disk_r;
  logic              wr_en;
  mbrp_cmd_t         cmd;
  mbrp_sts_t         sts;
  logic [IDX_W-1:0]  idx;

  // configuration registers
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= 1'b1;
      disk_r    <= '0;
    end else if (wr_en) begin
      if (cfg_paddr[3] == REG_SCAN_ENABLE) begin
        scan_en_r <= cfg_pwdata[0];
      end else begin
        disk_r <= cfg_pwdata[DISK_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_DISK_BYTES)
                    ? {{(APB_DW - DISK_W){1'b0}}, disk_r}
                    : {{(APB_DW - 1){1'b0}}, scan_en_r};

  mbrp_ctrl #(
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .scan_enable (scan_en_r),
    .sts         (sts),
    .cmd         (cmd),
    .idx         (idx)
  );

  mbrp_dp #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .idx              (idx),
    .byte_value       (in_chan.byte_value),
    .first_byte       (in_chan.first_byte),
    .disk_bytes       (disk_r),
    .sts              (sts),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_status       (out_chan.status),
    .out_slot         (out_chan.slot),
    .out_part_type    (out_chan.part_type),
    .out_start_byte   (out_chan.start_byte),
    .out_length_bytes (out_chan.length_bytes),
    .out_fits_disk    (out_chan.fits_disk),
    .out_last         (out_chan.last)
  );

endmodule

`default_nettype wire
